/* design/kssp_pkg.sv */
// ----------------------------------------------------------------------------
// kssp_pkg: keyboard serial status port definitions
// Shared operation codes, key length and the result record type.
// ----------------------------------------------------------------------------
package kssp_pkg;

    localparam int unsigned BITS_PER_KEY = 8;
    localparam int unsigned CNT_W        = 4;

    typedef enum logic [2:0] {
        OP_KBD_CTRL   = 3'd0,
        OP_KBD_READ   = 3'd1,
        OP_STAT_READ  = 3'd2,
        OP_CTRL_WRITE = 3'd3,
        OP_VSYNC      = 3'd4,
        OP_DISP_EN    = 3'd5,
        OP_RTC_READ   = 3'd6
    } op_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       kbd_irq_n;
        logic       nmi_assert;
        logic       nmi_release;
        logic [7:0] control_bits;
    } res_t;

endpackage

/* design/keyboard_serial_status_port.sv */
// ----------------------------------------------------------------------------
// keyboard_serial_status_port: keyboard receiver, control and status port
// Shifts keyboard bits, drives the keyboard interrupt, holds the control
// register, paces NMI from vsync and returns key and status bytes.
// ----------------------------------------------------------------------------
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | opcode, write_data, line_level
// result   | out_valid/out_stall| read_data, kbd_irq_n, nmi_assert, nmi_release,
//          |                    | memory_bank, char_mode_wide, rtc_irq_enable,
//          |                    | blank_video, video_ram_enable
//
// One transaction per cycle while in_stall is low; results are registered.
// State is updated at the input edge; a two-entry output buffer (result
// register plus skid register) lets input flow while a result waits.
// in_stall rises only when both output entries are full.
// rst_n clears all but result data asynchronously; irq resets to idle (high).
// ----------------------------------------------------------------------------
module keyboard_serial_status_port (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           opcode,
    input  logic [7:0]           write_data,
    input  logic                 line_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           read_data,
    output logic                 kbd_irq_n,
    output logic                 nmi_assert,
    output logic                 nmi_release,
    output logic [3:0]           memory_bank,
    output logic                 char_mode_wide,
    output logic                 rtc_irq_enable,
    output logic                 blank_video,
    output logic                 video_ram_enable
);
    import kssp_pkg::*;

    logic [7:0]       shift_byte_reg,   shift_byte_next;
    logic [CNT_W-1:0] bit_count_reg,    bit_count_next;
    logic             last_data_reg,    last_data_next;
    logic             last_clock_reg,   last_clock_next;
    logic             irq_n_reg,        irq_n_next;
    logic             vsync_phase_reg,  vsync_phase_next;
    logic [7:0]       control_reg,      control_next;
    logic             disp_en_reg,      disp_en_next;

    res_t             out_reg;
    res_t             skid_reg;
    res_t             res_next;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic             in_fire;
    logic             out_fire;
    logic             key_full;
    logic             data_lvl;
    logic             clock_lvl;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    assign key_full  = (bit_count_reg == CNT_W'(BITS_PER_KEY));
    assign data_lvl  = write_data[0];
    assign clock_lvl = write_data[1];

    always_comb
    begin
        shift_byte_next  = shift_byte_reg;
        bit_count_next   = bit_count_reg;
        last_data_next   = last_data_reg;
        last_clock_next  = last_clock_reg;
        irq_n_next       = irq_n_reg;
        vsync_phase_next = vsync_phase_reg;
        control_next     = control_reg;
        disp_en_next     = disp_en_reg;
        res_next         = '0;

        unique case (op_t'(opcode))
            OP_KBD_CTRL:
            begin
                if (key_full)
                begin
                    if (!last_data_reg && data_lvl)
                        irq_n_next = 1'b0;
                end
                else if (!last_clock_reg && clock_lvl)
                begin
                    shift_byte_next = {shift_byte_reg[6:0], data_lvl};
                    bit_count_next  = bit_count_reg + CNT_W'(1);
                end
                last_data_next  = data_lvl;
                last_clock_next = clock_lvl;
            end
            OP_KBD_READ:
            begin
                irq_n_next         = 1'b1;
                bit_count_next     = '0;
                res_next.read_data = shift_byte_reg;
            end
            OP_STAT_READ:
            begin
                res_next.read_data = {irq_n_reg, disp_en_reg, control_reg[5:4], 4'b0000};
            end
            OP_CTRL_WRITE:
            begin
                control_next = write_data;
            end
            OP_VSYNC:
            begin
                if (line_level)
                begin
                    vsync_phase_next    = !vsync_phase_reg;
                    res_next.nmi_assert = vsync_phase_reg && control_reg[5];
                end
            end
            OP_DISP_EN:
            begin
                disp_en_next = line_level;
            end
            OP_RTC_READ:
            begin
                res_next.nmi_release = 1'b1;
            end
            default:
            begin
            end
        endcase

        res_next.kbd_irq_n    = irq_n_next;
        res_next.control_bits = control_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg  <= '0;
            bit_count_reg   <= '0;
            last_data_reg   <= 1'b0;
            last_clock_reg  <= 1'b0;
            irq_n_reg       <= 1'b1;
            vsync_phase_reg <= 1'b0;
            control_reg     <= '0;
            disp_en_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            shift_byte_reg  <= shift_byte_next;
            bit_count_reg   <= bit_count_next;
            last_data_reg   <= last_data_next;
            last_clock_reg  <= last_clock_next;
            irq_n_reg       <= irq_n_next;
            vsync_phase_reg <= vsync_phase_next;
            control_reg     <= control_next;
            disp_en_reg     <= disp_en_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                if (out_valid_reg && !out_fire)
                    skid_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = out_reg.read_data;
    assign kbd_irq_n        = out_reg.kbd_irq_n;
    assign nmi_assert       = out_reg.nmi_assert;
    assign nmi_release      = out_reg.nmi_release;
    assign memory_bank      = out_reg.control_bits[3:0];
    assign char_mode_wide   = out_reg.control_bits[4];
    assign rtc_irq_enable   = out_reg.control_bits[5];
    assign blank_video      = out_reg.control_bits[6];
    assign video_ram_enable = out_reg.control_bits[7];

    // hold skid entry only behind a valid result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without result entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= CNT_W'(BITS_PER_KEY))
        else $error("bit count beyond key length");

    a_nmi_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.nmi_assert && out_reg.nmi_release))
        else $error("nmi raised and released in one transaction");

    a_kbd_read_release: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == OP_KBD_READ) |=> (irq_n_reg && bit_count_reg == '0))
        else $error("host read did not release interrupt");

    a_nmi_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == OP_VSYNC && line_level && vsync_phase_reg)
        |=> !vsync_phase_reg)
        else $error("vsync phase not reset on second edge");

endmodule
